// ----- rtl/rfae_pkg.sv -----
// Package: operation and status codes and field widths of the register file ALU executor.
package rfae_pkg;

  localparam int MODE_BITS   = 4;
  localparam int INDEX_BITS  = 4;
  localparam int VALUE_BITS  = 8;
  localparam int STATUS_BITS = 2;

  typedef logic [MODE_BITS-1:0]   mode_t;
  typedef logic [INDEX_BITS-1:0]  index_t;
  typedef logic [VALUE_BITS-1:0]  value_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam mode_t OP_ADD  = 4'd0;
  localparam mode_t OP_SUB  = 4'd1;
  localparam mode_t OP_MUL  = 4'd2;
  localparam mode_t OP_DIV  = 4'd3;
  localparam mode_t OP_AND  = 4'd4;
  localparam mode_t OP_OR   = 4'd5;
  localparam mode_t OP_XOR  = 4'd6;
  localparam mode_t OP_NOT  = 4'd7;
  localparam mode_t OP_SHL  = 4'd8;
  localparam mode_t OP_SHR  = 4'd9;
  localparam mode_t OP_MOV  = 4'd10;
  localparam mode_t OP_CMP  = 4'd11;
  localparam mode_t OP_A2D  = 4'd12;
  localparam mode_t OP_D2A  = 4'd13;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_DIVZERO = 2'd1;
  localparam status_t ST_BADOP   = 2'd2;

endpackage

// ----- rtl/rfae_in_if.sv -----
// Interface: instruction channel carrying one decoded instruction per item.
interface rfae_in_if
  import rfae_pkg::*;
();
  logic   valid;
  logic   ready;
  mode_t  mode;
  index_t first_source;
  index_t second_source;
  index_t destination;

  modport source (output valid, mode, first_source, second_source, destination, input ready);
  modport sink   (input valid, mode, first_source, second_source, destination, output ready);
endinterface

// ----- rtl/rfae_out_if.sv -----
// Interface: result channel reporting what one instruction wrote.
interface rfae_out_if
  import rfae_pkg::*;
();
  logic    valid;
  logic    ready;
  value_t  written_value;
  logic    wrote;
  status_t status;

  modport source (output valid, written_value, wrote, status, input ready);
  modport sink   (input valid, written_value, wrote, status, output ready);
endinterface

// ----- rtl/rfae_bank.sv -----
// Register bank: synchronous memory with two read ports, one write port and per-entry valid bits.
module rfae_bank #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] data_a_r;
  logic [WIDTH-1:0] data_b_r;
  logic             vld_a_r;
  logic             vld_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a_r <= mem[rd_addr_a];
      data_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_a_r <= vld_r[rd_addr_a];
        vld_b_r <= vld_r[rd_addr_b];
      end
    end
  end

  assign rd_data_a = vld_a_r ? data_a_r : '0;
  assign rd_data_b = vld_b_r ? data_b_r : '0;

endmodule

// ----- rtl/rfae_div.sv -----
// Divider: restoring unsigned division, one quotient bit per cycle.
module rfae_div #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic [WIDTH-1:0] quotient
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] quo_r;
  logic [WIDTH-1:0] den_r;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic             take;

  assign rem_sh = {rem_r, quo_r[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign take   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(WIDTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      quo_r <= {quo_r[WIDTH-2:0], take};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/register_file_alu_executor.sv -----
// Top level: executes decoded instructions on the A and D register banks.
// An instruction reads its operands from the banks in the cycle it is
// accepted and executes and writes back in the next, unless the output
// register holds an untaken result or it is a divide with a nonzero divisor,
// which waits for the one-bit-per-cycle divider; the next instruction is
// accepted once the write-back is done. A finished result sits in an output
// register and the block takes the next instruction while it waits; execution
// stalls only if a second result is ready before the first is taken. Both
// banks read as zero after reset without a clearing pass. Register indices wrap
// modulo BANK_DEPTH; written_value carries the low 8 bits of the value written.
module register_file_alu_executor
  import rfae_pkg::*;
#(
  parameter int BANK_DEPTH = 16,
  parameter int WORD_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  rfae_in_if.sink    in_chan,
  rfae_out_if.source out_chan
);

  localparam int AW  = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int SHW = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] SHIFT_LIM = WORD_BITS'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] VAL_ONE   = WORD_BITS'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  function automatic logic [AW-1:0] wrap_idx(input index_t raw);
    logic [6:0] v;
    v = 7'(raw);
    for (int i = 0; i < 8; i++) begin
      if (v >= 7'(BANK_DEPTH)) begin
        v = v - 7'(BANK_DEPTH);
      end
    end
    return AW'(v);
  endfunction

  logic [1:0]           state_r, state_nxt;
  mode_t                op_r;
  logic [AW-1:0]        dst_r;
  logic                 in_fire;
  logic [AW-1:0]        s1_idx, s2_idx;
  logic [WORD_BITS-1:0] x_val, y_val, d_val;
  logic [WORD_BITS-1:0] quo;
  logic                 div_busy;
  logic                 div_start;
  logic [2*WORD_BITS-1:0] prod;
  logic [WORD_BITS-1:0] val;
  logic                 wr_a, wr_d;
  status_t              status;
  logic                 can_emit;
  logic                 finish;

  logic                 out_valid_r;
  value_t               out_value_r;
  logic                 out_wrote_r;
  status_t              out_status_r;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign s1_idx        = wrap_idx(in_chan.first_source);
  assign s2_idx        = wrap_idx(in_chan.second_source);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_chan.mode;
      dst_r <= wrap_idx(in_chan.destination);
    end
  end

  rfae_bank #(
    .DEPTH (BANK_DEPTH),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_bank_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (s1_idx),
    .rd_addr_b (s2_idx),
    .rd_data_a (x_val),
    .rd_data_b (y_val),
    .wr_en     (wr_a),
    .wr_addr   (dst_r),
    .wr_data   (val)
  );

  rfae_bank #(
    .DEPTH (BANK_DEPTH),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_bank_d (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (s1_idx),
    .rd_addr_b (s1_idx),
    .rd_data_a (d_val),
    .rd_data_b (),
    .wr_en     (wr_d),
    .wr_addr   (dst_r),
    .wr_data   (val)
  );

  rfae_div #(
    .WIDTH (WORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (x_val),
    .divisor  (y_val),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign prod     = x_val * y_val;
  assign can_emit = !out_valid_r || out_chan.ready;

  always_comb begin
    val    = '0;
    status = ST_OK;
    unique case (op_r)
      OP_ADD: val = x_val + y_val;
      OP_SUB: val = x_val - y_val;
      OP_MUL: val = prod[WORD_BITS-1:0];
      OP_DIV: begin
        val = quo;
        if (y_val == '0) begin
          status = ST_DIVZERO;
        end
      end
      OP_AND: val = x_val & y_val;
      OP_OR:  val = x_val | y_val;
      OP_XOR: val = x_val ^ y_val;
      OP_NOT: val = ~x_val;
      OP_SHL: val = (y_val >= SHIFT_LIM) ? '0 : (x_val << y_val[SHW-1:0]);
      OP_SHR: val = (y_val >= SHIFT_LIM) ? '0 : (x_val >> y_val[SHW-1:0]);
      OP_MOV: val = x_val;
      OP_CMP: begin
        priority if (x_val > y_val) begin
          val = VAL_ONE;
        end else if (x_val < y_val) begin
          val = '1;
        end else begin
          val = '0;
        end
      end
      OP_A2D: val = x_val;
      OP_D2A: val = d_val;
      default: status = ST_BADOP;
    endcase
  end

  assign div_start = (state_r == S_EXEC) && (op_r == OP_DIV) && (y_val != '0);

  always_comb begin
    finish = 1'b0;
    unique case (state_r)
      S_EXEC:  finish = !div_start && can_emit;
      S_DIV:   finish = !div_busy && can_emit;
      default: finish = 1'b0;
    endcase
  end

  assign wr_a = finish && (status == ST_OK) && (op_r != OP_A2D);
  assign wr_d = finish && (op_r == OP_A2D);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (div_start) begin
          state_nxt = S_DIV;
        end else if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_wrote_r  <= wr_a || wr_d;
      out_status_r <= status;
      out_value_r  <= (wr_a || wr_d) ? val[VALUE_BITS-1:0] : '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.written_value = out_value_r;
  assign out_chan.wrote         = out_wrote_r;
  assign out_chan.status        = out_status_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execute");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (y_val != '0))
    else $error("divider started with zero divisor");

  a_write_reported: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_a || wr_d) |=> (out_valid_r && out_wrote_r && (out_status_r == ST_OK)))
    else $error("bank write not reported as written");

  a_single_bank: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> !(wr_a && wr_d))
    else $error("both banks written by one item");

  a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> !out_wrote_r)
    else $error("failed item reported a write");

endmodule

// ----- tb/register_file_alu_executor_tb.sv -----
// Testbench: directed and random instruction streams on the executor, checked by a bank model.
module register_file_alu_executor_tb
  import rfae_pkg::*;
();

  localparam mode_t OP_RESERVED_LO = 4'd14;
  localparam mode_t OP_RESERVED_HI = 4'd15;
  localparam int    BANK_SIZE      = 16;
  localparam int    SHIFT_LIMIT    = 8;
  localparam int    HOLD_CYCLES    = 200;
  localparam int    SETTLE_CYCLES  = 24;
  localparam int    CYCLE_LIMIT    = 400000;
  localparam int    PHASE_ITEMS    = 270;
  localparam int    MAX_REPORTS    = 10;

  typedef struct packed {
    value_t  written_value;
    logic    wrote;
    status_t status;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst_n;

  rfae_in_if  in_chan();
  rfae_out_if out_chan();

  value_t       a_regs [BANK_SIZE];
  value_t       d_regs [BANK_SIZE];
  exec_result_t pending_results [$];
  int           mismatches     = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  logic         hold_req       = 1'b0;
  logic         out_hold       = 1'b0;

  register_file_alu_executor uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #10 clk = ~clk;

  function automatic exec_result_t execute_instr(input mode_t op, input index_t s1,
                                                 input index_t s2, input index_t dst);
    value_t       x;
    value_t       y;
    value_t       val;
    exec_result_t res;
    x   = a_regs[s1];
    y   = a_regs[s2];
    val = '0;
    res.written_value = '0;
    res.wrote         = 1'b1;
    res.status        = ST_OK;
    case (op)
      OP_ADD: val = x + y;
      OP_SUB: val = x - y;
      OP_MUL: val = x * y;
      OP_DIV: begin
        if (y != 0) begin
          val = x / y;
        end else begin
          res.wrote  = 1'b0;
          res.status = ST_DIVZERO;
        end
      end
      OP_AND: val = x & y;
      OP_OR:  val = x | y;
      OP_XOR: val = x ^ y;
      OP_NOT: val = ~x;
      OP_SHL: val = (y >= SHIFT_LIMIT) ? '0 : x << y;
      OP_SHR: val = (y >= SHIFT_LIMIT) ? '0 : x >> y;
      OP_MOV: val = x;
      OP_CMP: val = (x > y) ? value_t'(1) : ((x < y) ? '1 : '0);
      OP_A2D: val = x;
      OP_D2A: val = d_regs[s1];
      default: begin
        res.wrote  = 1'b0;
        res.status = ST_BADOP;
      end
    endcase
    if (res.wrote) begin
      if (op == OP_A2D) begin
        d_regs[dst] = val;
      end else begin
        a_regs[dst] = val;
      end
      res.written_value = val;
    end
    return res;
  endfunction

  task automatic send_instr(input mode_t op, input index_t s1, input index_t s2,
                            input index_t dst);
    exec_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid         <= 1'b1;
    in_chan.mode          <= op;
    in_chan.first_source  <= s1;
    in_chan.second_source <= s2;
    in_chan.destination   <= dst;
    do @(posedge clk); while (!in_chan.ready);
    res = execute_instr(op, s1, s2, dst);
    pending_results.push_back(res);
  endtask

  task automatic send_random_instr();
    send_instr(mode_t'($urandom_range(15)), index_t'($urandom_range(15)),
               index_t'($urandom_range(15)), index_t'($urandom_range(15)));
  endtask

  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hold the result channel off for a fixed stretch on request
  initial begin
    forever begin
      wait (hold_req);
      out_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_hold <= 1'b0;
      wait (!hold_req);
    end
  end

  always @(posedge clk) begin : check_results
    exec_result_t got;
    exec_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.written_value = out_chan.written_value;
      got.wrote         = out_chan.wrote;
      got.status        = out_chan.status;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: value %0d wrote %0b status %0d",
                   got.written_value, got.wrote, got.status);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display({"result mismatch: expected value %0d wrote %0b status %0d,",
                      " got value %0d wrote %0b status %0d"},
                     want.written_value, want.wrote, want.status,
                     got.written_value, got.wrote, got.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("register_file_alu_executor verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_instr(OP_DIV, 0, 0, 5);
    send_instr(OP_RESERVED_LO, 15, 15, 15);
    send_instr(OP_RESERVED_HI, 0, 15, 0);
    send_instr(OP_NOT, 0, 9, 1);
    send_instr(OP_CMP, 1, 0, 2);
    send_instr(OP_CMP, 0, 1, 3);
    send_instr(OP_CMP, 1, 1, 4);
    send_instr(OP_ADD, 1, 2, 5);
    send_instr(OP_ADD, 1, 1, 5);
    send_instr(OP_SUB, 0, 2, 6);
    send_instr(OP_MUL, 1, 1, 7);
    send_instr(OP_SHL, 2, 2, 8);
    send_instr(OP_SHL, 8, 8, 10);
    send_instr(OP_SHL, 1, 10, 11);
    send_instr(OP_SHR, 1, 10, 11);
    send_instr(OP_SUB, 10, 2, 12);
    send_instr(OP_SHL, 2, 12, 13);
    send_instr(OP_SHR, 1, 12, 13);
    send_instr(OP_SHR, 1, 1, 14);
    send_instr(OP_DIV, 1, 8, 14);
    send_instr(OP_DIV, 5, 0, 1);
    send_instr(OP_AND, 1, 12, 15);
    send_instr(OP_OR, 8, 10, 15);
    send_instr(OP_XOR, 1, 12, 15);
    send_instr(OP_MOV, 1, 3, 9);
    send_instr(OP_A2D, 1, 0, 15);
    send_instr(OP_D2A, 15, 0, 0);
    send_instr(OP_D2A, 0, 15, 15);
    wait_for_results();
  endtask

  task automatic test_random_stream();
    int idle_pcts [4];
    int stall_pcts [4];
    idle_pcts  = '{0, 88, 0, 11};
    stall_pcts = '{0, 0, 88, 11};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      repeat (PHASE_ITEMS) send_random_instr();
      wait_for_results();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (40) send_random_instr();
    wait_for_results();
    hold_req = 1'b0;
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.mode          = OP_ADD;
    in_chan.first_source  = '0;
    in_chan.second_source = '0;
    in_chan.destination   = '0;
    foreach (a_regs[i]) begin
      a_regs[i] = '0;
      d_regs[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_stream();
    test_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("register_file_alu_executor verification clean");
    end else begin
      $display("register_file_alu_executor verification failed");
    end
    $finish;
  end

endmodule

// ----- register_file_alu_executor.f -----
rtl/rfae_pkg.sv
rtl/rfae_in_if.sv
rtl/rfae_out_if.sv
rtl/rfae_bank.sv
rtl/rfae_div.sv
rtl/register_file_alu_executor.sv
tb/register_file_alu_executor_tb.sv
